/* hw/rtl/aes128_block_encrypt_defines.svh */
// Shared assertion macros for the AES-128 encrypt block.
`ifndef AES128_BLOCK_ENCRYPT_DEFINES_SVH
`define AES128_BLOCK_ENCRYPT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define AES128_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, checked outside reset.
`define AES128_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

/* hw/rtl/aes128_pkg.sv */
package aes128_pkg;

  localparam int NUM_ROUNDS = 10;
  localparam int KEY_WORDS  = 44;
  localparam int KEY_ROWS   = KEY_WORDS / 4;
  localparam int ROW_W      = $clog2(KEY_ROWS);
  localparam int WORD_W     = 32;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_ENCRYPT = 1'b1;

  typedef struct packed {
    logic             key_we;
    logic             load_pt;
    logic             kadd;
    logic             rnd;
    logic             out_load;
    logic [ROW_W-1:0] rd_row;
  } ctrl_cmd_t;

  function automatic logic [7:0] gf_x2(input logic [7:0] v);
    gf_x2 = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_square(input logic [7:0] v);
    logic [7:0] r;
    r = {1'b0, v[3], 1'b0, v[2], 1'b0, v[1], 1'b0, v[0]};
    if (v[4]) r = r ^ 8'h1B;
    if (v[5]) r = r ^ 8'h6C;
    if (v[6]) r = r ^ 8'hAB;
    if (v[7]) r = r ^ 8'h9A;
    gf_square = r;
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] p, input logic [7:0] q);
    logic [7:0] acc;
    logic [7:0] pp;
    acc = 8'h00;
    pp  = p;
    for (int i = 0; i < 8; i++) begin
      if (q[i]) acc = acc ^ pp;
      pp = gf_x2(pp);
    end
    gf_mul = acc;
  endfunction

  // x^254 by addition chain; zero maps to zero
  function automatic logic [7:0] gf_inv(input logic [7:0] v);
    logic [7:0] p2, p3, p12, p14, p15, p240;
    p2   = gf_square(v);
    p3   = gf_mul(p2, v);
    p12  = gf_square(gf_square(p3));
    p14  = gf_mul(p12, p2);
    p15  = gf_mul(p12, p3);
    p240 = gf_square(gf_square(gf_square(gf_square(p15))));
    gf_inv = gf_mul(p240, p14);
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] v);
    logic [7:0] t;
    t = gf_inv(v);
    sbox = t ^ {t[6:0], t[7]} ^ {t[5:0], t[7:6]} ^ {t[4:0], t[7:5]} ^
           {t[3:0], t[7:4]} ^ 8'h63;
  endfunction

  function automatic logic [31:0] mix_column(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3, all;
    a0  = w[7:0];
    a1  = w[15:8];
    a2  = w[23:16];
    a3  = w[31:24];
    all = a0 ^ a1 ^ a2 ^ a3;
    mix_column = {a3 ^ all ^ gf_x2(a3 ^ a0), a2 ^ all ^ gf_x2(a2 ^ a3),
                  a1 ^ all ^ gf_x2(a1 ^ a2), a0 ^ all ^ gf_x2(a0 ^ a1)};
  endfunction

endpackage

/* hw/rtl/aes128_ram.sv */
module aes128_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/aes128_ctrl.sv */
`include "aes128_block_encrypt_defines.svh"

module aes128_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_cmd,
  output logic                  out_valid,
  input  logic                  out_ready,
  output aes128_pkg::ctrl_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;
  localparam logic [aes128_pkg::ROW_W-1:0] LAST_ROUND =
    aes128_pkg::ROW_W'(aes128_pkg::NUM_ROUNDS);

  logic                          state_r, state_nxt;
  logic [aes128_pkg::ROW_W-1:0]  round_r, round_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          accept;
  logic                          out_free;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    round_nxt    = round_r;
    cmd          = '0;
    cmd.key_we   = accept && (in_cmd == aes128_pkg::CMD_LOAD);
    unique case (state_r)
      ST_IDLE: begin
        round_nxt = '0;
        if (accept && (in_cmd == aes128_pkg::CMD_ENCRYPT)) begin
          cmd.load_pt = 1'b1;
          state_nxt   = ST_RUN;
        end
      end
      ST_RUN: begin
        if (round_r == '0) begin
          cmd.kadd  = 1'b1;
          round_nxt = round_r + 1'b1;
        end else if (round_r != LAST_ROUND) begin
          cmd.rnd   = 1'b1;
          round_nxt = round_r + 1'b1;
        end else if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
          round_nxt    = '0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    cmd.rd_row = round_nxt;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      round_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `AES128_ASSERT_IMPL(a_round_range, clk, rst_n, 1'b1, round_r <= LAST_ROUND)
  `AES128_ASSERT_NEXT(a_enc_start, clk, rst_n,
    accept && (in_cmd == aes128_pkg::CMD_ENCRYPT), state_r == ST_RUN && round_r == '0)
  `AES128_ASSERT_NEXT(a_done_out, clk, rst_n, cmd.out_load, out_valid_r && state_r == ST_IDLE)
  `AES128_ASSERT_IMPL(a_idle_round, clk, rst_n, state_r == ST_IDLE, round_r == '0)

endmodule

/* hw/rtl/aes128_dp.sv */
module aes128_dp (
  input  logic                  clk,
  input  aes128_pkg::ctrl_cmd_t cmd,
  input  logic [5:0]            key_index,
  input  logic [31:0]           key_word,
  input  logic [63:0]           block_lo,
  input  logic [63:0]           block_hi,
  output logic [63:0]           cipher_lo,
  output logic [63:0]           cipher_hi
);

  logic [127:0] state_r, state_nxt;
  logic [127:0] out_r;
  logic [127:0] rk;
  logic [127:0] sub;
  logic [127:0] shifted;
  logic [127:0] mixed;
  logic [127:0] round_out;
  logic         idx_ok;

  assign idx_ok = key_index < 6'(aes128_pkg::KEY_WORDS);

  for (genvar b = 0; b < 4; b++) begin : g_bank
    aes128_ram #(
      .WIDTH(aes128_pkg::WORD_W),
      .DEPTH(aes128_pkg::KEY_ROWS)
    ) u_ram (
      .clk  (clk),
      .we   (cmd.key_we && idx_ok && (key_index[1:0] == 2'(b))),
      .waddr(key_index[5:2]),
      .wdata(key_word),
      .raddr(cmd.rd_row),
      .rdata(rk[32*b +: 32])
    );
  end

  for (genvar i = 0; i < 16; i++) begin : g_sbox
    assign sub[8*i +: 8] = aes128_pkg::sbox(state_r[8*i +: 8]);
  end

  // byte r of column c comes from column c+r
  for (genvar c = 0; c < 4; c++) begin : g_col
    for (genvar r = 0; r < 4; r++) begin : g_row
      assign shifted[32*c + 8*r +: 8] = sub[32*((c + r) % 4) + 8*r +: 8];
    end
    assign mixed[32*c +: 32] = aes128_pkg::mix_column(shifted[32*c +: 32]);
  end

  // final round skips the column mix
  assign round_out = (cmd.out_load ? shifted : mixed) ^ rk;

  always_comb begin
    state_nxt = state_r;
    if (cmd.load_pt) state_nxt = {block_hi, block_lo};
    else if (cmd.kadd) state_nxt = state_r ^ rk;
    else if (cmd.rnd) state_nxt = round_out;
  end

  always_ff @(posedge clk) begin
    state_r <= state_nxt;
    if (cmd.out_load) out_r <= round_out;
  end

  assign cipher_lo = out_r[63:0];
  assign cipher_hi = out_r[127:64];

endmodule

/* hw/rtl/aes128_block_encrypt.sv */
// An encrypt item runs a key add plus ten rounds through one shared round unit; the last round
// writes the output register, and waits for that while a previous result is still unaccepted.
// No new item is taken until then; a key-word load leaves the block idle and ready.
// The round key is read from a registered key store one round ahead.
// Reset (rst_n low, synchronous): controller to idle, result flag cleared.
// The key store is not cleared and must be loaded before use.
module aes128_block_encrypt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [5:0]  in_key_index,
  input  logic [31:0] in_key_word,
  input  logic [63:0] in_block_lo,
  input  logic [63:0] in_block_hi,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_cipher_lo,
  output logic [63:0] out_cipher_hi
);

  // Command bundle from the sequencer to the round datapath.
  aes128_pkg::ctrl_cmd_t cmd;

  // Sequencer: accepts items, steps the round count, hands off the result.
  aes128_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_cmd),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd)
  );

  // Datapath: key store banks, state register, one round unit, result register.
  aes128_dp u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .key_index(in_key_index),
    .key_word (in_key_word),
    .block_lo (in_block_lo),
    .block_hi (in_block_hi),
    .cipher_lo(out_cipher_lo),
    .cipher_hi(out_cipher_hi)
  );

endmodule

/* bench/aes128_block_encrypt_check.sv */
`timescale 1ns / 100ps
module aes128_block_encrypt_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_cmd,
  input  logic [5:0]  in_key_index,
  input  logic [31:0] in_key_word,
  input  logic [63:0] in_block_lo,
  input  logic [63:0] in_block_hi,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_cipher_lo,
  input  logic [63:0] out_cipher_hi,
  output int          fail_count,
  output int          pending_count
);
  import aes128_pkg::*;

  logic [31:0] key_store [KEY_WORDS];
  logic [127:0] cipher_q [$];

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] field_mul(input logic [7:0] p, input logic [7:0] q);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (q[i]) acc ^= p;
      p = xtime(p);
    end
    return acc;
  endfunction

  // invert by brute power x^254, then affine map
  function automatic logic [7:0] sub_byte(input logic [7:0] v);
    logic [7:0] t;
    t = 8'h01;
    for (int i = 0; i < 254; i++) t = field_mul(t, v);
    return t ^ {t[6:0], t[7]} ^ {t[5:0], t[7:6]} ^ {t[4:0], t[7:5]} ^
           {t[3:0], t[7:4]} ^ 8'h63;
  endfunction

  logic [7:0] sub_lut [256];
  initial for (int i = 0; i < 256; i++) sub_lut[i] = sub_byte(i[7:0]);

  function automatic logic [127:0] encrypt_block(input logic [127:0] pt);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] res;
    for (int b = 0; b < 16; b++)
      s[b] = pt[8*b +: 8] ^ key_store[b/4][8*(b%4) +: 8];
    for (int r = 1; r <= NUM_ROUNDS; r++) begin
      // byte 4c+row takes from column c+row
      for (int c = 0; c < 4; c++)
        for (int row = 0; row < 4; row++)
          t[4*c+row] = sub_lut[s[4*((c+row)%4)+row]];
      for (int c = 0; c < 4; c++) begin
        if (r < NUM_ROUNDS) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
          t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
          t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
          t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        for (int row = 0; row < 4; row++)
          s[4*c+row] = t[4*c+row] ^ key_store[4*r+c][8*row +: 8];
      end
    end
    for (int b = 0; b < 16; b++) res[8*b +: 8] = s[b];
    return res;
  endfunction

  assign pending_count = cipher_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    logic [127:0] want;
    if (rst_n && in_valid && in_ready) begin
      if (in_cmd == CMD_LOAD) begin
        if (in_key_index < KEY_WORDS) key_store[in_key_index] = in_key_word;
      end else
        cipher_q.push_back(encrypt_block({in_block_hi, in_block_lo}));
    end
    if (rst_n && out_valid && out_ready) begin
      if (cipher_q.size() == 0) begin
        $display("%0t: unexpected item, actual %h %h", $time, out_cipher_hi, out_cipher_lo);
        fail_count++;
      end else begin
        want = cipher_q.pop_front();
        if (out_cipher_lo !== want[63:0]) begin
          $display("%0t: cipher_lo expected %h actual %h", $time, want[63:0], out_cipher_lo);
          fail_count++;
        end
        if (out_cipher_hi !== want[127:64]) begin
          $display("%0t: cipher_hi expected %h actual %h", $time, want[127:64],
                   out_cipher_hi);
          fail_count++;
        end
      end
    end
  end
endmodule

/* bench/aes128_block_encrypt_test.sv */
`timescale 1ns / 100ps
module aes128_block_encrypt_test;
  import aes128_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_cmd = CMD_LOAD;
  logic [5:0]  in_key_index = '0;
  logic [31:0] in_key_word = '0;
  logic [63:0] in_block_lo = '0;
  logic [63:0] in_block_hi = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_cipher_lo;
  logic [63:0] out_cipher_hi;
  int          fail_count;
  int          pending_count;

  int send_idle_pct = 13;
  int recv_idle_pct = 87;
  bit hold_off = 1'b0;
  int cycle_count = 0;

  aes128_block_encrypt dut (.*);

  aes128_block_encrypt_check checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ceiling: ~1100 items, stalls about 8x, plus slack
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("aes128_block_encrypt_test: errors");
      $finish;
    end
  end

  // receiver: random stalls, forced low during a hold-off
  always @(posedge clk)
    out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);

  // present one item and wait until it is taken; drop valid only for idle gaps
  task automatic offer_item(input logic cmd, input logic [5:0] idx, input logic [31:0] word,
                            input logic [63:0] lo, input logic [63:0] hi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_key_index <= idx;
    in_key_word  <= word;
    in_block_lo  <= lo;
    in_block_hi  <= hi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // load all 44 words; flavor=0 zeros, 1 ones, else random
  task automatic load_schedule(input int flavor);
    logic [31:0] w;
    for (int i = 0; i < KEY_WORDS; i++) begin
      w = (flavor == 0) ? 32'h0 : (flavor == 1) ? 32'hffffffff : $urandom;
      offer_item(CMD_LOAD, i[5:0], w, rand64(), rand64());
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_phase(input int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 80)
        offer_item(CMD_ENCRYPT, 6'($urandom), $urandom, rand64(), rand64());
      else if (pick < 95)
        // rewrite a key word mid-stream
        offer_item(CMD_LOAD, 6'($urandom_range(KEY_WORDS - 1)), $urandom, rand64(), rand64());
      else
        // out-of-range index: ignored
        offer_item(CMD_LOAD, 6'($urandom_range(63, KEY_WORDS)), $urandom, rand64(), rand64());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes of key and block, ignored loads
    load_schedule(0);
    offer_item(CMD_ENCRYPT, 6'h3f, 32'hffffffff, 64'h0, 64'h0);
    offer_item(CMD_ENCRYPT, 6'h0, 32'h0, '1, '1);
    offer_item(CMD_LOAD, 6'd44, 32'hdeadbeef, '1, '1);
    offer_item(CMD_LOAD, 6'd63, 32'hffffffff, '0, '0);
    offer_item(CMD_ENCRYPT, 6'h0, 32'h0, 64'h0123456789abcdef, 64'hfedcba9876543210);
    load_schedule(1);
    offer_item(CMD_ENCRYPT, 6'h0, 32'h0, 64'h0, 64'h0);
    offer_item(CMD_ENCRYPT, 6'h0, 32'h0, '1, '1);
    load_schedule(2);

    random_phase(300);
    send_idle_pct = 87;
    recv_idle_pct = 13;
    random_phase(150);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(200);

    // back-pressure: stall receiver while items keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      random_phase(40);
    join

    random_phase(200);
    drain();
    if (fail_count == 0)
      $display("aes128_block_encrypt_test: clean");
    else
      $display("aes128_block_encrypt_test: errors");
    $finish;
  end
endmodule
